>>> design/wis_pkg.sv
// Shared types and constants for the weighted index sampler.
// No dependencies; used by wis_ctrl, wis_dp and the top level.
`timescale 1ns / 1ps

package wis_pkg;

  // Table geometry
  localparam int unsigned MaxEntries = 1024;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);
  localparam int unsigned WeightW    = 64;

  // Stream payload widths
  localparam int unsigned InDataW  = 128;  // stake, roll
  localparam int unsigned InUserW  = 2;    // opcode
  localparam int unsigned OutDataW = 80;   // entry_index, total_weight, zero fill
  localparam int unsigned OutUserW = 3;    // status

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_RANGE    = 3'd1,
    STS_EMPTY    = 3'd2,
    STS_FULL     = 3'd3,
    STS_OVERFLOW = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH,
    ST_FINISH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // latch the input transfer
    logic exec;    // run clear / append / lookup checks, start search
    logic step;    // one binary search step
    logic emit;    // move the result into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_search;  // lookup passed its checks (valid in EXEC)
    logic search_last;  // current step closes the search
    logic out_free;     // output register can take a result
  } dp_sts_t;

endpackage

>>> design/weighted_index_sampler_unit.sv
// Weighted index sampler: one item in, one result out over stream channels.
// Depends on wis_pkg, wis_ctrl and wis_dp.
`timescale 1ns / 1ps

// Keeps up to 1024 cumulative-weight starts in an on-chip table. Clear and
// append items are latched, executed and moved into the output register; a
// lookup adds binary search steps between execute and output, up to 11 for a
// full table, each one waiting on the registered read of the start table.
// One item is in work at a time; input tready is high only while the unit
// is idle, and a finished result sits in the output register until taken.
// Status (tuser) reports ok, roll out of range, empty table, full table or
// sum overflow; entry_index is zero unless status is ok.
module weighted_index_sampler_unit import wis_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // stake[63:0], roll[127:64]
  input  logic [InUserW-1:0]  s_axis_tuser,   // opcode[1:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // entry_index[9:0], total_weight[73:10]
  output logic [OutUserW-1:0] m_axis_tuser    // status[2:0]
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer
  wis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table, search and output register
  wis_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_user_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_user_o  (m_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

endmodule

>>> design/wis_ctrl.sv
// Sequencer for the weighted index sampler.
// Depends on wis_pkg; drives wis_dp through dp_cmd_t, watches dp_sts_t.
`timescale 1ns / 1ps

module wis_ctrl import wis_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = sts_i.need_search ? ST_SEARCH : ST_FINISH;
      end
      ST_SEARCH: begin
        if (sts_i.search_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_EXEC:   cmd_o.exec = 1'b1;
      ST_SEARCH: cmd_o.step = 1'b1;
      ST_FINISH: cmd_o.emit = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

>>> design/wis_dp.sv
// Datapath of the weighted index sampler: start table, running total,
// search bounds, result and output registers. Depends on wis_pkg.
`timescale 1ns / 1ps

module wis_dp import wis_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o,
  input  logic [InUserW-1:0]   in_user_i,
  input  logic [InDataW-1:0]   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OutUserW-1:0]  out_user_o,
  output logic [OutDataW-1:0]  out_data_o
);

  localparam int unsigned PadW = OutDataW - IdxW - WeightW;

  // Start-of-interval table
  logic [WeightW-1:0] mem [MaxEntries];
  logic [WeightW-1:0] rd_q;
  logic               mem_we;
  logic [IdxW-1:0]    mem_ra;

  // Latched input item
  opcode_e            op_q;
  logic [WeightW-1:0] stake_q, roll_q;

  // Architectural state
  logic [WeightW-1:0] total_q, total_d;
  logic [CntW-1:0]    count_q, count_d;

  // Search bounds
  logic [CntW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [CntW-1:0] lo_n, hi_n, mid_n;
  logic            s_le;

  // Result and output registers
  status_e            res_sts_q, res_sts_d;
  logic [IdxW-1:0]    res_idx_q, res_idx_d;
  logic               out_valid_q;
  status_e            out_sts_q;
  logic [IdxW-1:0]    out_idx_q;
  logic [WeightW-1:0] out_total_q;

  logic [WeightW:0] sum;
  logic             table_full;
  logic             lookup_ok;

  assign sum        = {1'b0, total_q} + {1'b0, stake_q};
  assign table_full = (count_q == CntW'(MaxEntries));
  assign lookup_ok  = (op_q == OP_LOOKUP) && (count_q != '0) && (roll_q < total_q);

  // One search step: narrow the bounds on the entry just read
  always_comb begin
    s_le  = (rd_q <= roll_q);
    lo_n  = s_le ? (mid_q + CntW'(1)) : lo_q;
    hi_n  = s_le ? hi_q : mid_q;
    mid_n = lo_n + ((hi_n - lo_n) >> 1);
  end

  assign sts_o.need_search = lookup_ok;
  assign sts_o.search_last = (lo_n >= hi_n);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  // Item execution and search sequencing
  always_comb begin
    total_d   = total_q;
    count_d   = count_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    res_sts_d = res_sts_q;
    res_idx_d = res_idx_q;
    mem_we    = 1'b0;
    mem_ra    = mid_n[IdxW-1:0];
    if (cmd_i.exec) begin
      res_sts_d = STS_OK;
      res_idx_d = '0;
      lo_d      = '0;
      hi_d      = count_q;
      mid_d     = count_q >> 1;
      mem_ra    = mid_d[IdxW-1:0];
      unique case (op_q)
        OP_CLEAR: begin
          total_d = '0;
          count_d = '0;
        end
        OP_APPEND: begin
          priority if (table_full) begin
            res_sts_d = STS_FULL;
          end else if (sum[WeightW]) begin
            res_sts_d = STS_OVERFLOW;
          end else begin
            mem_we    = 1'b1;
            total_d   = sum[WeightW-1:0];
            count_d   = count_q + CntW'(1);
            res_idx_d = count_q[IdxW-1:0];
          end
        end
        OP_LOOKUP: begin
          priority if (count_q == '0) begin
            res_sts_d = STS_EMPTY;
          end else if (roll_q >= total_q) begin
            res_sts_d = STS_RANGE;
          end
        end
        OP_NONE: ;
        default: ;
      endcase
    end else if (cmd_i.step) begin
      lo_d  = lo_n;
      hi_d  = hi_n;
      mid_d = mid_n;
      if (sts_o.search_last) begin
        res_idx_d = IdxW'(lo_n - CntW'(1));
      end
    end
  end

  // Table write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[IdxW-1:0]] <= total_q;
    end
    rd_q <= mem[mem_ra];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      total_q <= total_d;
      count_q <= count_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= opcode_e'(in_user_i);
      stake_q <= in_data_i[WeightW-1:0];
      roll_q  <= in_data_i[2*WeightW-1:WeightW];
    end
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    res_sts_q <= res_sts_d;
    res_idx_q <= res_idx_d;
    if (cmd_i.emit) begin
      out_sts_q   <= res_sts_q;
      out_idx_q   <= res_idx_q;
      out_total_q <= total_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_user_o  = out_sts_q;
  assign out_data_o  = {{PadW{1'b0}}, out_total_q, out_idx_q};

endmodule
